// File: rtl/core/i2c_master_register_access_unit_assert.svh
// assertion macros for the i2c register access unit
// used by the top level only, no other dependencies
`ifndef I2C_MASTER_REGISTER_ACCESS_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define I2CRA_ASSERT_IMPLIES(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("i2cra assertion failed");
`define I2CRA_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("i2cra assertion failed");
`else
`define I2CRA_ASSERT_IMPLIES(label, clk, rst, a, b)
`define I2CRA_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// File: rtl/core/i2cra_pkg.sv
// types, codes and segment tables for the i2c register access unit
// no dependencies
`default_nettype none
package i2cra_pkg;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_ALT_TICK = 2'd3;

   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef logic [2:0] seg_type;

   localparam seg_type SEG_START = 3'd0;
   localparam seg_type SEG_DEV   = 3'd1;
   localparam seg_type SEG_REG   = 3'd2;
   localparam seg_type SEG_DATA  = 3'd3;
   localparam seg_type SEG_DEVR  = 3'd4;
   localparam seg_type SEG_RECV  = 3'd5;
   localparam seg_type SEG_NACK  = 3'd6;
   localparam seg_type SEG_STOP  = 3'd7;

   // offset within a byte segment where the ack bit begins
   localparam logic [4:0] BYTE_ACK_OFF = 5'd24;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] seg_idx;
      logic [4:0] off;
      logic [1:0] ph;
      logic [2:0] bit_idx;
      logic [7:0] dev_byte;
      logic [7:0] reg_byte;
      logic [7:0] data_byte;
      logic [7:0] shift;
      logic [7:0] last_read;
      logic       scl;
      logic       sda;
   } state_type;

   function automatic logic [4:0] seg_len(input seg_type seg);
      logic [4:0] len;
      case (seg)
         SEG_START: len = 5'd4;
         SEG_DEV, SEG_REG, SEG_DATA, SEG_DEVR: len = 5'd27;
         SEG_RECV: len = 5'd17;
         default: len = 5'd3;
      endcase
      return len;
   endfunction

   function automatic seg_type seg_of(input logic [1:0] kind, input logic [2:0] idx);
      seg_type seg;
      if (kind == KIND_READ) begin
         case (idx)
            3'd0: seg = SEG_START;
            3'd1: seg = SEG_DEV;
            3'd2: seg = SEG_REG;
            3'd3: seg = SEG_START;
            3'd4: seg = SEG_DEVR;
            3'd5: seg = SEG_RECV;
            3'd6: seg = SEG_NACK;
            default: seg = SEG_STOP;
         endcase
      end else begin
         case (idx)
            3'd0: seg = SEG_START;
            3'd1: seg = SEG_DEV;
            3'd2: seg = SEG_REG;
            3'd3: seg = SEG_DATA;
            default: seg = SEG_STOP;
         endcase
      end
      return seg;
   endfunction

   function automatic logic [2:0] plan_last(input logic [1:0] kind);
      return (kind == KIND_READ) ? 3'd7 : 3'd4;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/i2cra_if.sv
// valid/ready channel interfaces for the i2c register access unit
// no dependencies
`default_nettype none
interface i2cra_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] dev_address;
   logic [7:0] reg_address;
   logic [7:0] write_data;
   logic       sda_in;

   modport source (output valid, op, dev_address, reg_address, write_data, sda_in,
                   input ready);
   modport sink (input valid, op, dev_address, reg_address, write_data, sda_in,
                 output ready);
endinterface

interface i2cra_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl;
   logic       sda;
   logic       busy_res;
   logic [7:0] read_data;
   logic       read_valid;

   modport source (output valid, scl, sda, busy_res, read_data, read_valid,
                   input ready);
   modport sink (input valid, scl, sda, busy_res, read_data, read_valid,
                 output ready);
endinterface
`default_nettype wire

// File: rtl/core/i2c_master_register_access_unit.sv
// Bit-banged I2C master for register writes and reads. Each accepted item is either a
// command (op 1 write, op 2 read, taken only while idle) or a tick that moves SCL/SDA
// by one line change; every item yields exactly one result with the line levels, busy
// flag and last read byte. One item is taken per clock cycle while the result side is
// not stalled; the item sits in the input register while one step of the line
// sequencer runs, and the result register captures that step when the item fires.
// A register write is a command plus 88 ticks, a register read a command plus 112 ticks;
// read_valid marks the last tick.
// depends on i2cra_pkg, i2cra_if, i2cra_step and the assertion header
`default_nettype none
`include "i2c_master_register_access_unit_assert.svh"
module i2c_master_register_access_unit (
   input wire logic   clock,
   input wire logic   reset,
   i2cra_req_if.sink  req,
   i2cra_rsp_if.source rsp
);

   logic       in_valid_ff;
   logic [1:0] in_op_ff;
   logic [7:0] in_dev_ff;
   logic [7:0] in_reg_ff;
   logic [7:0] in_data_ff;
   logic       in_sda_ff;

   i2cra_pkg::state_type state_ff, state_in;
   logic read_done;

   logic       out_valid_ff;
   logic       out_scl_ff;
   logic       out_sda_ff;
   logic       out_busy_ff;
   logic [7:0] out_read_data_ff;
   logic       out_read_valid_ff;

   logic fire;

   assign fire      = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) begin
         in_op_ff   <= req.op;
         in_dev_ff  <= req.dev_address;
         in_reg_ff  <= req.reg_address;
         in_data_ff <= req.write_data;
         in_sda_ff  <= req.sda_in;
      end
   end

   i2cra_step u_step (
      .op          (in_op_ff),
      .dev_address (in_dev_ff),
      .reg_address (in_reg_ff),
      .write_data  (in_data_ff),
      .sda_in      (in_sda_ff),
      .cur         (state_ff),
      .nxt         (state_in),
      .read_done   (read_done)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.kind      <= i2cra_pkg::KIND_NONE;
         state_ff.seg_idx   <= 3'd0;
         state_ff.off       <= 5'd0;
         state_ff.ph        <= 2'd0;
         state_ff.bit_idx   <= 3'd0;
         state_ff.dev_byte  <= 8'd0;
         state_ff.reg_byte  <= 8'd0;
         state_ff.data_byte <= 8'd0;
         state_ff.shift     <= 8'd0;
         state_ff.last_read <= 8'd0;
         state_ff.scl       <= 1'b1;
         state_ff.sda       <= 1'b1;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (fire) begin
         out_scl_ff        <= state_in.scl;
         out_sda_ff        <= state_in.sda;
         out_busy_ff       <= (state_in.kind != i2cra_pkg::KIND_NONE);
         out_read_data_ff  <= state_in.last_read;
         out_read_valid_ff <= read_done;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.scl        = out_scl_ff;
   assign rsp.sda        = out_sda_ff;
   assign rsp.busy_res   = out_busy_ff;
   assign rsp.read_data  = out_read_data_ff;
   assign rsp.read_valid = out_read_valid_ff;

   // a completed read always leaves the sequencer idle
   `I2CRA_ASSERT_NEXT(a_read_ends_idle, clock, reset, fire && read_done,
                      state_ff.kind == i2cra_pkg::KIND_NONE)
   // idle sequencer sits at the first step
   `I2CRA_ASSERT_IMPLIES(a_idle_at_origin, clock, reset,
                         state_ff.kind == i2cra_pkg::KIND_NONE,
                         state_ff.seg_idx == 3'd0 && state_ff.off == 5'd0)
   // a held input transaction is not dropped
   `I2CRA_ASSERT_NEXT(a_input_held, clock, reset, in_valid_ff && !fire, in_valid_ff)
   // result busy flag matches the stored transaction kind
   `I2CRA_ASSERT_NEXT(a_busy_tracks_kind, clock, reset, fire,
                      out_busy_ff == (state_ff.kind != i2cra_pkg::KIND_NONE))

endmodule
`default_nettype wire

// File: rtl/core/i2cra_step.sv
// one step of the i2c line sequencer: next state from current state and item
// depends on i2cra_pkg
`default_nettype none
module i2cra_step (
   input  wire logic [1:0]          op,
   input  wire logic [7:0]          dev_address,
   input  wire logic [7:0]          reg_address,
   input  wire logic [7:0]          write_data,
   input  wire logic                sda_in,
   input  wire i2cra_pkg::state_type cur,
   output i2cra_pkg::state_type      nxt,
   output logic                      read_done
);

   i2cra_pkg::seg_type seg;
   logic [7:0] tx_byte;
   logic       seg_end;
   logic       is_byte;

   always_comb begin
      seg = i2cra_pkg::seg_of(cur.kind, cur.seg_idx);
      seg_end = (cur.off == i2cra_pkg::seg_len(seg) - 5'd1);
      is_byte = (seg == i2cra_pkg::SEG_DEV) || (seg == i2cra_pkg::SEG_REG) ||
                (seg == i2cra_pkg::SEG_DATA) || (seg == i2cra_pkg::SEG_DEVR);
      unique case (seg)
         i2cra_pkg::SEG_DEV:  tx_byte = cur.dev_byte;
         i2cra_pkg::SEG_REG:  tx_byte = cur.reg_byte;
         i2cra_pkg::SEG_DATA: tx_byte = cur.data_byte;
         default:             tx_byte = cur.dev_byte + 8'd1;
      endcase
   end

   always_comb begin
      nxt = cur;
      read_done = 1'b0;
      if (cur.kind == i2cra_pkg::KIND_NONE) begin
         if (op == i2cra_pkg::OP_WRITE || op == i2cra_pkg::OP_READ) begin
            nxt.dev_byte  = dev_address;
            nxt.reg_byte  = reg_address;
            nxt.data_byte = write_data;
            nxt.kind      = op;
            nxt.seg_idx   = 3'd0;
            nxt.off       = 5'd0;
            nxt.ph        = 2'd0;
            nxt.bit_idx   = 3'd0;
         end
      end else if (op == i2cra_pkg::OP_TICK || op == i2cra_pkg::OP_ALT_TICK) begin
         unique case (seg)
            i2cra_pkg::SEG_START: begin
               unique case (cur.off[1:0])
                  2'd0: nxt.sda = 1'b1;
                  2'd1: nxt.scl = 1'b1;
                  2'd2: nxt.sda = 1'b0;
                  default: nxt.scl = 1'b0;
               endcase
            end
            i2cra_pkg::SEG_DEV, i2cra_pkg::SEG_REG, i2cra_pkg::SEG_DATA,
            i2cra_pkg::SEG_DEVR: begin
               priority if (cur.off < i2cra_pkg::BYTE_ACK_OFF) begin
                  priority case (cur.ph)
                     2'd0: nxt.sda = tx_byte[3'd7 - cur.bit_idx];
                     2'd1: nxt.scl = 1'b1;
                     default: nxt.scl = 1'b0;
                  endcase
               end else if (cur.off == i2cra_pkg::BYTE_ACK_OFF) begin
                  // release sda for the slave ack
                  nxt.sda = 1'b1;
               end else if (cur.off == i2cra_pkg::BYTE_ACK_OFF + 5'd1) begin
                  nxt.scl = 1'b1;
               end else begin
                  nxt.scl = 1'b0;
               end
            end
            i2cra_pkg::SEG_RECV: begin
               priority if (cur.off == 5'd0) begin
                  nxt.sda   = 1'b1;
                  nxt.shift = 8'd0;
               end else if (cur.off[0]) begin
                  nxt.scl = 1'b1;
               end else begin
                  // sample while scl is still high, then lower it
                  nxt.shift = {cur.shift[6:0], sda_in};
                  nxt.scl   = 1'b0;
               end
            end
            i2cra_pkg::SEG_NACK: begin
               priority if (cur.off == 5'd0) nxt.sda = 1'b1;
               else if (cur.off == 5'd1) nxt.scl = 1'b1;
               else nxt.scl = 1'b0;
            end
            default: begin
               priority if (cur.off == 5'd0) nxt.sda = 1'b0;
               else if (cur.off == 5'd1) nxt.scl = 1'b1;
               else nxt.sda = 1'b1;
            end
         endcase

         // the phase counter wraps every bit; the bit counter wraps back to zero after the eighth bit
         if (is_byte && cur.off < i2cra_pkg::BYTE_ACK_OFF) begin
            if (cur.ph == 2'd2) begin
               nxt.ph      = 2'd0;
               nxt.bit_idx = cur.bit_idx + 3'd1;
            end else begin
               nxt.ph = cur.ph + 2'd1;
            end
         end

         if (seg_end) begin
            nxt.off = 5'd0;
            if (cur.seg_idx == i2cra_pkg::plan_last(cur.kind)) begin
               if (cur.kind == i2cra_pkg::KIND_READ) begin
                  nxt.last_read = cur.shift;
                  read_done     = 1'b1;
               end
               nxt.kind    = i2cra_pkg::KIND_NONE;
               nxt.seg_idx = 3'd0;
            end else begin
               nxt.seg_idx = cur.seg_idx + 3'd1;
            end
         end else begin
            nxt.off = cur.off + 5'd1;
         end
      end
   end

endmodule
`default_nettype wire

// File: tb/i2c_master_register_access_unit_checker.sv
// checker for the i2c register access unit: watches both channels, predicts
// the line levels and read byte of every accepted transaction and compares them
// depends on i2cra_pkg and i2cra_if
`timescale 1ns / 1ps
module i2c_master_register_access_unit_checker (
   input  logic  clock,
   input  logic  reset,
   i2cra_req_if  req_mon,
   i2cra_rsp_if  rsp_mon,
   output int    fail_count,
   output int    outstanding
);

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy_res;
      logic [7:0] read_data;
      logic       read_valid;
   } line_result_type;

   line_result_type line_results_due[$];

   // predicted sequencer state
   logic [6:0] step_idx;
   logic [1:0] active_kind;
   logic [7:0] dev_latch;
   logic [7:0] reg_latch;
   logic [7:0] data_latch;
   logic [7:0] rx_shift;
   logic [7:0] last_byte;
   logic       scl_level;
   logic       sda_level;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic i2cra_pkg::seg_type segment_at(input logic [1:0] kind, input int idx);
      i2cra_pkg::seg_type seg;
      seg = i2cra_pkg::SEG_STOP;
      case (idx)
         0: seg = i2cra_pkg::SEG_START;
         1: seg = i2cra_pkg::SEG_DEV;
         2: seg = i2cra_pkg::SEG_REG;
         3: seg = (kind == i2cra_pkg::KIND_READ) ? i2cra_pkg::SEG_START : i2cra_pkg::SEG_DATA;
         4: seg = (kind == i2cra_pkg::KIND_READ) ? i2cra_pkg::SEG_DEVR : i2cra_pkg::SEG_STOP;
         5: seg = i2cra_pkg::SEG_RECV;
         6: seg = i2cra_pkg::SEG_NACK;
         default: seg = i2cra_pkg::SEG_STOP;
      endcase
      return seg;
   endfunction

   function automatic int ticks_in(input i2cra_pkg::seg_type seg);
      int n;
      case (seg)
         i2cra_pkg::SEG_START: n = 4;
         i2cra_pkg::SEG_RECV:  n = 17;
         i2cra_pkg::SEG_NACK, i2cra_pkg::SEG_STOP: n = 3;
         default:   n = 27;
      endcase
      return n;
   endfunction

   // eight data bits of three ticks each, then the ack slot with sda released
   task automatic shift_out_step(input logic [7:0] byte_val, input int off);
      if (off < 24) begin
         case (off % 3)
            0: sda_level = byte_val[7 - off / 3];
            1: scl_level = 1'b1;
            default: scl_level = 1'b0;
         endcase
      end else if (off == 24) begin
         sda_level = 1'b1;
      end else begin
         scl_level = (off == 25);
      end
   endtask

   task automatic line_change(input i2cra_pkg::seg_type seg, input int off,
                              input logic sda_sample);
      case (seg)
         i2cra_pkg::SEG_START: begin
            if (off == 0) sda_level = 1'b1;
            else if (off == 1) scl_level = 1'b1;
            else if (off == 2) sda_level = 1'b0;
            else scl_level = 1'b0;
         end
         i2cra_pkg::SEG_DEV:  shift_out_step(dev_latch, off);
         i2cra_pkg::SEG_REG:  shift_out_step(reg_latch, off);
         i2cra_pkg::SEG_DATA: shift_out_step(data_latch, off);
         i2cra_pkg::SEG_DEVR: shift_out_step(dev_latch + 8'd1, off);
         i2cra_pkg::SEG_RECV: begin
            if (off == 0) begin
               sda_level = 1'b1;
               rx_shift  = 8'h00;
            end else if (off % 2 == 1) begin
               scl_level = 1'b1;
            end else begin
               // sample while scl is still high, msb first
               rx_shift  = {rx_shift[6:0], sda_sample};
               scl_level = 1'b0;
            end
         end
         i2cra_pkg::SEG_NACK: begin
            if (off == 0) sda_level = 1'b1;
            else scl_level = (off == 1);
         end
         default: begin
            if (off == 0) sda_level = 1'b0;
            else if (off == 1) scl_level = 1'b1;
            else sda_level = 1'b1;
         end
      endcase
   endtask

   task automatic advance_lines(input logic [1:0] op, input logic [7:0] dev,
                                input logic [7:0] reg_b, input logic [7:0] dat,
                                input logic sda_sample, output line_result_type res);
      int nseg;
      int off;
      int idx;
      logic done_read;
      done_read = 1'b0;
      if (active_kind == i2cra_pkg::KIND_NONE) begin
         if (op == i2cra_pkg::OP_WRITE || op == i2cra_pkg::OP_READ) begin
            dev_latch   = dev;
            reg_latch   = reg_b;
            data_latch  = dat;
            active_kind = op;
            step_idx    = '0;
         end
      end else if (op == i2cra_pkg::OP_TICK || op == i2cra_pkg::OP_ALT_TICK) begin
         // commands while busy skip this branch and change nothing
         nseg = (active_kind == i2cra_pkg::KIND_READ) ? 8 : 5;
         off  = int'(step_idx);
         idx  = 0;
         while (idx < nseg && off >= ticks_in(segment_at(active_kind, idx))) begin
            off -= ticks_in(segment_at(active_kind, idx));
            idx++;
         end
         if (idx < nseg) begin
            line_change(segment_at(active_kind, idx), off, sda_sample);
            step_idx = step_idx + 7'd1;
            if (idx == nseg - 1 && off + 1 == ticks_in(segment_at(active_kind, idx))) begin
               if (active_kind == i2cra_pkg::KIND_READ) begin
                  last_byte = rx_shift;
                  done_read = 1'b1;
               end
               active_kind = i2cra_pkg::KIND_NONE;
               step_idx    = '0;
            end
         end else begin
            active_kind = i2cra_pkg::KIND_NONE;
            step_idx    = '0;
         end
      end
      res.scl        = scl_level;
      res.sda        = sda_level;
      res.busy_res   = (active_kind != i2cra_pkg::KIND_NONE);
      res.read_data  = last_byte;
      res.read_valid = done_read;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      line_result_type due;
      if (reset) begin
         step_idx    = '0;
         active_kind = i2cra_pkg::KIND_NONE;
         dev_latch   = '0;
         reg_latch   = '0;
         data_latch  = '0;
         rx_shift    = '0;
         last_byte   = '0;
         scl_level   = 1'b1;
         sda_level   = 1'b1;
         line_results_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            advance_lines(req_mon.op, req_mon.dev_address, req_mon.reg_address,
                          req_mon.write_data, req_mon.sda_in, due);
            line_results_due.push_back(due);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (line_results_due.size() == 0) begin
               $error("result transaction with no request outstanding");
               fail_count++;
            end else begin
               due = line_results_due.pop_front();
               check_field("scl", 8'(due.scl), 8'(rsp_mon.scl));
               check_field("sda", 8'(due.sda), 8'(rsp_mon.sda));
               check_field("busy_res", 8'(due.busy_res), 8'(rsp_mon.busy_res));
               check_field("read_data", due.read_data, rsp_mon.read_data);
               check_field("read_valid", 8'(due.read_valid), 8'(rsp_mon.read_valid));
            end
         end
      end
      outstanding = line_results_due.size();
   end

endmodule

// File: tb/i2c_master_register_access_unit_tb.sv
// testbench top for the i2c register access unit: drives register write and
// read sequences with random idling and gives the verdict
// depends on i2cra_pkg, i2cra_if, the unit and its checker
`timescale 1ns / 1ps
module i2c_master_register_access_unit_tb;

   localparam int ITEM_GOAL   = 1550;
   localparam int WRITE_TICKS = 88;
   localparam int READ_TICKS  = 112;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   item_count = 0;
   bit   sender_idle_en = 1'b0;
   bit   sink_stall_en = 1'b0;

   i2cra_req_if req_ch ();
   i2cra_rsp_if rsp_ch ();

   i2c_master_register_access_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   i2c_master_register_access_unit_checker checker_inst (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   initial begin
      #3000000;
      $display("i2c_master_register_access_unit_tb: FAIL");
      $finish;
   end

   // result side back-pressure in random bursts
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (sink_stall_en && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 13) - 1) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic put_item(input logic [1:0] op, input logic [7:0] dev,
                           input logic [7:0] reg_b, input logic [7:0] dat, input logic sda);
      if (sender_idle_en && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.op          <= op;
      req_ch.dev_address <= dev;
      req_ch.reg_address <= reg_b;
      req_ch.write_data  <= dat;
      req_ch.sda_in      <= sda;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      item_count++;
      @(negedge clock);
   endtask

   task automatic put_noise_tick(input logic [1:0] op, input logic sda);
      put_item(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)), sda);
   endtask

   // sda_mode: 0 random, 1 all ones, 2 all zeros
   task automatic run_sequence(input logic [1:0] cmd, input logic [7:0] dev,
                               input logic [7:0] reg_b, input logic [7:0] dat,
                               input int sda_mode, input bit noisy, input int n_ticks);
      logic sda;
      logic [1:0] tick_op;
      put_item(cmd, dev, reg_b, dat, 1'($urandom_range(0, 1)));
      for (int k = 0; k < n_ticks; k++) begin
         // stray command while busy, must be ignored
         if (noisy && $urandom_range(0, 29) == 0)
            put_noise_tick($urandom_range(0, 1) ? i2cra_pkg::OP_WRITE : i2cra_pkg::OP_READ,
                           1'($urandom_range(0, 1)));
         sda = (sda_mode == 1) ? 1'b1 : (sda_mode == 2) ? 1'b0 : 1'($urandom_range(0, 1));
         tick_op = (noisy && $urandom_range(0, 3) == 0) ? i2cra_pkg::OP_ALT_TICK
                                                        : i2cra_pkg::OP_TICK;
         put_noise_tick(tick_op, sda);
      end
   endtask

   task automatic drain_pause();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
   endtask

   initial begin
      logic [1:0] cmd;
      int n;
      int pick;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.op          = i2cra_pkg::OP_TICK;
      req_ch.dev_address = '0;
      req_ch.reg_address = '0;
      req_ch.write_data  = '0;
      req_ch.sda_in      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: idle ticks, field extremes, address wrap on read
      put_noise_tick(i2cra_pkg::OP_TICK, 1'b1);
      put_noise_tick(i2cra_pkg::OP_ALT_TICK, 1'b0);
      run_sequence(i2cra_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h00, 0, 1'b0, WRITE_TICKS);
      run_sequence(i2cra_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hFF, 0, 1'b1, WRITE_TICKS);
      run_sequence(i2cra_pkg::OP_READ, 8'hFF, 8'h00, 8'h5A, 1, 1'b0, READ_TICKS);
      run_sequence(i2cra_pkg::OP_READ, 8'h00, 8'hFF, 8'hA5, 2, 1'b1, READ_TICKS);
      run_sequence(i2cra_pkg::OP_READ, 8'hA5, 8'h5A, 8'h00, 0, 1'b1, READ_TICKS);
      drain_pause();

      while (item_count < ITEM_GOAL) begin
         if (item_count > ITEM_GOAL - 220) begin
            sender_idle_en = 1'b0;
            sink_stall_en  = 1'b0;
         end else begin
            sender_idle_en = ($urandom_range(0, 9) < 7);
            sink_stall_en  = ($urandom_range(0, 9) < 7);
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            repeat ($urandom_range(1, 4))
               put_noise_tick($urandom_range(0, 1) ? i2cra_pkg::OP_TICK : i2cra_pkg::OP_ALT_TICK,
                              1'($urandom_range(0, 1)));
         end else if (pick == 1) begin
            drain_pause();
         end else begin
            cmd = $urandom_range(0, 1) ? i2cra_pkg::OP_WRITE : i2cra_pkg::OP_READ;
            n = (cmd == i2cra_pkg::OP_READ) ? READ_TICKS : WRITE_TICKS;
            // occasionally cut a sequence short so the next command lands while busy
            if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
            run_sequence(cmd, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)),
                         ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0, 1'b1, n);
         end
      end

      drain_pause();
      repeat (16) @(posedge clock);
      if (fail_count == 0)
         $display("i2c_master_register_access_unit_tb: PASS");
      else
         $display("i2c_master_register_access_unit_tb: FAIL");
      $finish;
   end

endmodule
